// File: design/skpc_pkg.sv
`timescale 1ns / 1ps
package skpc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PEAK,
        S_NORM,
        S_SQ_MUL,
        S_SQ_ACC,
        S_DB_MUL,
        S_DB_FIN,
        S_KNEE,
        S_LIN_MUL,
        S_LIN_FIN,
        S_X2_MUL,
        S_SL_MUL,
        S_DIV_LD,
        S_DIV,
        S_DIV_FIN,
        S_REL_M1,
        S_REL_M2,
        S_REL_FIN,
        S_ATT_M1,
        S_ATT_M2,
        S_ATT_FIN,
        S_EXP_MUL,
        S_EXP_E,
        S_EXP_C3,
        S_EXP_C2,
        S_EXP_C1,
        S_EXP_FIN,
        S_MIX_MUL,
        S_MIX_FIN,
        S_CH_MUL,
        S_CH_FIN,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        CFG_THRESHOLD = 4'd0,
        CFG_SLOPE     = 4'd1,
        CFG_KNEE      = 4'd2,
        CFG_ATTACK    = 4'd3,
        CFG_RELEASE   = 4'd4,
        CFG_MAKEUP    = 4'd5,
        CFG_WET_MIX   = 4'd6,
        CFG_BYPASS    = 4'd7
    } t_cfg_idx;

    localparam logic [31:0] DB_PER_LOG2_Q16     = 32'd394566;
    localparam logic [31:0] LOG2_10_OVER_20_Q24 = 32'd2786635;
    localparam logic [31:0] EXP_C1              = 32'd747141773;
    localparam logic [31:0] EXP_C2              = 32'd242730077;
    localparam logic [31:0] EXP_C3              = 32'd83880711;
    localparam logic [15:0] DB_FLOOR_Q88        = 16'd25600;
    localparam logic signed [25:0] GAIN_FLOOR_Q816 = -26'sd6553600;
    localparam logic [24:0] ONE_Q24             = 25'h1000000;
    localparam logic [16:0] WET_FULL            = 17'd65536;

    localparam logic [14:0] RST_THRESHOLD = 15'd28160;
    localparam logic [15:0] RST_SLOPE     = 16'd49152;
    localparam logic [12:0] RST_KNEE      = 13'd1536;
    localparam logic [23:0] RST_ATTACK    = 24'd16742300;
    localparam logic [23:0] RST_RELEASE   = 24'd16773721;
    localparam logic [12:0] RST_MAKEUP    = 13'd0;
    localparam logic [16:0] RST_WET_MIX   = 17'd65536;

endpackage

// File: design/soft_knee_peak_compressor.sv
`timescale 1ns / 1ps
// feed-forward soft-knee peak compressor, one frame of CHANNELS samples per request
// input stream (s_axis): one frame per request, channel 0 in the lowest bits
// output stream (m_axis): processed samples, then the 15-bit gain reduction (Q7.8 dB)
// config channel: index and data, always ready; write only while the block is idle
// sequencing: a 16-step log2 squaring loop and a 33-step knee divide, and every
//   multiply in the chain goes through one shared 32x32 multiplier in turn
// throughput: one frame at a time, s_axis tready is high only in idle
// the output register holds a finished result while the next frame is taken in;
//   if the receiver stalls, the next result waits in the sequencer until the
//   output register empties
// bypass: samples pass through, reduction reads zero, envelope state holds
// reset (synchronous, active low): registers go to their defaults, envelope to zero,
//   output register empties
module soft_knee_peak_compressor
    import skpc_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input frame
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata: left_sample, right_sample (one per channel), zero pad
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // output frame
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // tdata: left_out, right_out (one per channel), reduction_db, zero pad
    output logic [((CHANNELS*SAMPLE_BITS+15+7)/8)*8-1:0] o_m_axis_tdata,
    // configuration writes
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [3:0] i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EW   = $clog2(SAMPLE_BITS);
    localparam int LW   = EW + 16;
    localparam int OD_W = ((CHANNELS*SAMPLE_BITS+15+7)/8)*8;
    localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS-1);
    localparam logic [LW-1:0] FULL_L  = LW'((SAMPLE_BITS-1) * 65536);
    localparam logic [39:0] SMAX      = 40'((64'd1 << (SAMPLE_BITS-1)) - 64'd1);

    // control and configuration
    t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic signed [14:0] r_thr, n_thr;
    logic [15:0] r_slope, n_slope;
    logic [12:0] r_knee, n_knee;
    logic [23:0] r_ac, n_ac;
    logic [23:0] r_rc, n_rc;
    logic [12:0] r_mk, n_mk;
    logic [16:0] r_wet, n_wet;
    logic r_byp, n_byp;
    logic [23:0] r_rel, n_rel;
    logic [23:0] r_att, n_att;

    // datapath
    logic [SB-1:0] r_x [CHANNELS];
    logic [SB-1:0] n_x [CHANNELS];
    logic [SB-1:0] r_y [CHANNELS];
    logic [SB-1:0] n_y [CHANNELS];
    logic [OD_W-1:0] r_odata, n_odata;
    logic [SB-1:0] r_peak, n_peak;
    logic [CW-1:0] r_ch, n_ch;
    logic [SB-1:0] r_nrm, n_nrm;
    logic [EW-1:0] r_e, n_e;
    logic [30:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [5:0] r_it, n_it;
    logic signed [15:0] r_lvl, n_lvl;
    logic signed [17:0] r_o, n_o;
    logic [13:0] r_x2, n_x2;
    logic [32:0] r_dq, n_dq;
    logic [12:0] r_rem, n_rem;
    logic [23:0] r_tgt, n_tgt;
    logic [63:0] r_acc, n_acc;
    logic [14:0] r_red, n_red;
    logic r_dneg, n_dneg;
    logic [15:0] r_f, n_f;
    logic signed [10:0] r_sh, n_sh;
    logic [30:0] r_g, n_g;
    logic [30:0] r_gsum, n_gsum;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;

    // combinational helpers
    logic [SB-1:0] cur_x, cur_abs, pk_now;
    logic [SB+30:0] nrm_ext;
    logic [31:0] sq;
    logic [LW-1:0] l_val, neg_l;
    logic [63:0] rnd, sum;
    logic signed [17:0] k_o;
    logic signed [18:0] k_2o, k_k;
    logic [13:0] rem_sh;
    logic rem_ok;
    logic signed [25:0] d_w;
    logic [25:0] ad;
    logic [25:0] biased;
    logic [31:0] exp_m;
    logic [16:0] w_eff, dry;
    logic [39:0] mag;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    assign cur_x   = r_x[r_ch];
    assign cur_abs = cur_x[SB-1] ? (~cur_x + 1'b1) : cur_x;
    assign pk_now  = (cur_abs > r_peak) ? cur_abs : r_peak;
    assign nrm_ext = {r_nrm, 31'b0};
    assign w_eff   = (r_wet > WET_FULL) ? WET_FULL : r_wet;
    assign dry     = WET_FULL - w_eff;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid;
        n_thr = r_thr;
        n_slope = r_slope;
        n_knee = r_knee;
        n_ac = r_ac;
        n_rc = r_rc;
        n_mk = r_mk;
        n_wet = r_wet;
        n_byp = r_byp;
        n_rel = r_rel;
        n_att = r_att;
        n_x = r_x;
        n_y = r_y;
        n_odata = r_odata;
        n_peak = r_peak;
        n_ch = r_ch;
        n_nrm = r_nrm;
        n_e = r_e;
        n_m = r_m;
        n_frac = r_frac;
        n_it = r_it;
        n_lvl = r_lvl;
        n_o = r_o;
        n_x2 = r_x2;
        n_dq = r_dq;
        n_rem = r_rem;
        n_tgt = r_tgt;
        n_acc = r_acc;
        n_red = r_red;
        n_dneg = r_dneg;
        n_f = r_f;
        n_sh = r_sh;
        n_g = r_g;
        n_gsum = r_gsum;
        mul_a = '0;
        mul_b = '0;

        sq = r_prod[61:30];
        l_val = {r_e, r_frac};
        neg_l = (FULL_L > l_val) ? (FULL_L - l_val) : '0;
        rnd = r_prod + 64'd8388608;
        sum = r_acc + r_prod;
        k_o = 18'(r_lvl) - 18'(r_thr);
        k_2o = {k_o, 1'b0};
        k_k = $signed({6'b0, r_knee});
        rem_sh = {r_rem, r_dq[32]};
        rem_ok = (rem_sh >= {1'b0, r_knee});
        d_w = $signed({5'b0, r_mk, 8'b0}) - $signed({2'b0, r_att});
        ad = d_w[25] ? 26'(-d_w) : 26'(d_w);
        biased = r_dneg ? (26'(ONE_Q24) - 26'(r_prod[47:24]))
                        : (26'(ONE_Q24) + 26'(r_prod[47:24]));
        exp_m = 32'h40000000 + r_prod[47:16];
        mag = rnd[63:24];

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: n_thr = i_cfg_data[14:0];
                CFG_SLOPE:     n_slope = i_cfg_data[15:0];
                CFG_KNEE:      n_knee = i_cfg_data[12:0];
                CFG_ATTACK:    n_ac = i_cfg_data[23:0];
                CFG_RELEASE:   n_rc = i_cfg_data[23:0];
                CFG_MAKEUP:    n_mk = i_cfg_data[12:0];
                CFG_WET_MIX:   n_wet = i_cfg_data[16:0];
                CFG_BYPASS:    n_byp = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_x[c] = i_s_axis_tdata[c*SB +: SB];
                    end
                    n_peak = '0;
                    n_ch = '0;
                    n_state = S_PEAK;
                end
            end
            S_PEAK: begin
                n_peak = pk_now;
                if (r_ch == LAST_CH) begin
                    if (r_byp) begin
                        n_state = S_DONE;
                    end else if (pk_now == '0) begin
                        // silent frame sits at the floor
                        n_lvl = -$signed(DB_FLOOR_Q88);
                        n_state = S_KNEE;
                    end else begin
                        n_nrm = pk_now;
                        n_e = EW'(SB-1);
                        n_state = S_NORM;
                    end
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_NORM: begin
                if (r_nrm[SB-1]) begin
                    n_m = nrm_ext[SB+30 -: 31];
                    n_frac = '0;
                    n_it = '0;
                    n_state = S_SQ_MUL;
                end else begin
                    n_nrm = r_nrm << 1;
                    n_e = r_e - 1'b1;
                end
            end
            S_SQ_MUL: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                n_m = sq[31] ? sq[31:1] : sq[30:0];
                n_frac = {r_frac[14:0], sq[31]};
                if (r_it == 6'd15) begin
                    n_state = S_DB_MUL;
                end else begin
                    n_it = r_it + 1'b1;
                    n_state = S_SQ_MUL;
                end
            end
            S_DB_MUL: begin
                mul_a = 32'(neg_l);
                mul_b = DB_PER_LOG2_Q16;
                n_state = S_DB_FIN;
            end
            S_DB_FIN: begin
                if (mag > 40'(DB_FLOOR_Q88)) begin
                    n_lvl = -$signed(DB_FLOOR_Q88);
                end else begin
                    n_lvl = -$signed({1'b0, mag[14:0]});
                end
                n_state = S_KNEE;
            end
            S_KNEE: begin
                n_o = k_o;
                if (k_2o <= -k_k) begin
                    n_tgt = '0;
                    n_state = S_REL_M1;
                end else if (k_2o >= k_k) begin
                    n_state = S_LIN_MUL;
                end else begin
                    n_x2 = 14'(k_2o + k_k);
                    n_state = S_X2_MUL;
                end
            end
            S_LIN_MUL: begin
                mul_a = 32'(r_o[16:0]);
                mul_b = 32'(r_slope);
                n_state = S_LIN_FIN;
            end
            S_LIN_FIN: begin
                n_tgt = r_prod[31:8];
                n_state = S_REL_M1;
            end
            S_X2_MUL: begin
                mul_a = 32'(r_x2);
                mul_b = 32'(r_x2);
                n_state = S_SL_MUL;
            end
            S_SL_MUL: begin
                mul_a = r_prod[31:0];
                mul_b = 32'(r_slope);
                n_state = S_DIV_LD;
            end
            S_DIV_LD: begin
                // divide by 2048*knee as a shift then a divide by knee
                n_dq = r_prod[43:11];
                n_rem = '0;
                n_it = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = rem_ok ? 13'(rem_sh - {1'b0, r_knee}) : rem_sh[12:0];
                n_dq = {r_dq[31:0], rem_ok};
                if (r_it == 6'd32) begin
                    n_state = S_DIV_FIN;
                end else begin
                    n_it = r_it + 1'b1;
                end
            end
            S_DIV_FIN: begin
                n_tgt = r_dq[23:0];
                n_state = S_REL_M1;
            end
            S_REL_M1: begin
                mul_a = 32'(r_rc);
                mul_b = 32'(r_rel);
                n_state = S_REL_M2;
            end
            S_REL_M2: begin
                n_acc = r_prod;
                mul_a = 32'(ONE_Q24 - {1'b0, r_rc});
                mul_b = 32'(r_tgt);
                n_state = S_REL_FIN;
            end
            S_REL_FIN: begin
                // release stage never drops below the target
                n_rel = (sum[63:24] < 40'(r_tgt)) ? r_tgt : sum[47:24];
                n_state = S_ATT_M1;
            end
            S_ATT_M1: begin
                mul_a = 32'(r_ac);
                mul_b = 32'(r_att);
                n_state = S_ATT_M2;
            end
            S_ATT_M2: begin
                n_acc = r_prod;
                mul_a = 32'(ONE_Q24 - {1'b0, r_ac});
                mul_b = 32'(r_rel);
                n_state = S_ATT_FIN;
            end
            S_ATT_FIN: begin
                n_att = sum[47:24];
                n_red = sum[47] ? 15'h7FFF : sum[46:32];
                n_state = S_EXP_MUL;
            end
            S_EXP_MUL: begin
                mul_a = 32'(ad);
                mul_b = LOG2_10_OVER_20_Q24;
                n_dneg = d_w[25];
                if (d_w <= GAIN_FLOOR_Q816) begin
                    n_g = '0;
                    n_state = S_MIX_MUL;
                end else begin
                    n_state = S_EXP_E;
                end
            end
            S_EXP_E: begin
                n_f = biased[15:0];
                n_sh = 11'sd262 - $signed({1'b0, biased[25:16]});
                n_state = S_EXP_C3;
            end
            S_EXP_C3: begin
                mul_a = EXP_C3;
                mul_b = 32'(r_f);
                n_state = S_EXP_C2;
            end
            S_EXP_C2: begin
                mul_a = EXP_C2 + r_prod[47:16];
                mul_b = 32'(r_f);
                n_state = S_EXP_C1;
            end
            S_EXP_C1: begin
                mul_a = EXP_C1 + r_prod[47:16];
                mul_b = 32'(r_f);
                n_state = S_EXP_FIN;
            end
            S_EXP_FIN: begin
                if (r_sh > 11'sd40) begin
                    n_g = '0;
                end else if (r_sh < 11'sd0) begin
                    n_g = exp_m[30:0];
                end else begin
                    n_g = 31'(exp_m >> r_sh[5:0]);
                end
                n_state = S_MIX_MUL;
            end
            S_MIX_MUL: begin
                mul_a = 32'(r_g);
                mul_b = 32'(w_eff);
                n_state = S_MIX_FIN;
            end
            S_MIX_FIN: begin
                n_gsum = 31'((64'(dry) << 24) + r_prod >> 16);
                n_ch = '0;
                n_state = S_CH_MUL;
            end
            S_CH_MUL: begin
                mul_a = 32'(cur_abs);
                mul_b = 32'(r_gsum);
                n_state = S_CH_FIN;
            end
            S_CH_FIN: begin
                // round, restore sign, saturate
                if (!cur_x[SB-1]) begin
                    n_y[r_ch] = (mag > SMAX) ? SMAX[SB-1:0] : mag[SB-1:0];
                end else if (mag > SMAX + 40'd1) begin
                    n_y[r_ch] = {1'b1, {(SB-1){1'b0}}};
                end else begin
                    n_y[r_ch] = ~mag[SB-1:0] + 1'b1;
                end
                if (r_ch == LAST_CH) begin
                    n_state = S_DONE;
                end else begin
                    n_ch = r_ch + 1'b1;
                    n_state = S_CH_MUL;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_odata = '0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_odata[c*SB +: SB] = r_byp ? r_x[c] : r_y[c];
                    end
                    n_odata[CHANNELS*SB +: 15] = r_byp ? 15'd0 : r_red;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_thr <= RST_THRESHOLD;
            r_slope <= RST_SLOPE;
            r_knee <= RST_KNEE;
            r_ac <= RST_ATTACK;
            r_rc <= RST_RELEASE;
            r_mk <= RST_MAKEUP;
            r_wet <= RST_WET_MIX;
            r_byp <= 1'b0;
            r_rel <= '0;
            r_att <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_thr <= n_thr;
            r_slope <= n_slope;
            r_knee <= n_knee;
            r_ac <= n_ac;
            r_rc <= n_rc;
            r_mk <= n_mk;
            r_wet <= n_wet;
            r_byp <= n_byp;
            r_rel <= n_rel;
            r_att <= n_att;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        r_x <= n_x;
        r_y <= n_y;
        r_odata <= n_odata;
        r_peak <= n_peak;
        r_ch <= n_ch;
        r_nrm <= n_nrm;
        r_e <= n_e;
        r_m <= n_m;
        r_frac <= n_frac;
        r_it <= n_it;
        r_lvl <= n_lvl;
        r_o <= n_o;
        r_x2 <= n_x2;
        r_dq <= n_dq;
        r_rem <= n_rem;
        r_tgt <= n_tgt;
        r_acc <= n_acc;
        r_red <= n_red;
        r_dneg <= n_dneg;
        r_f <= n_f;
        r_sh <= n_sh;
        r_g <= n_g;
        r_gsum <= n_gsum;
    end

endmodule
